[design/cvtf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cvtf_pkg
// Shared types, widths and saturation helpers of the constant-velocity
// track filter.
// -----------------------------------------------------------------------------
package cvtf_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 66;   // 33 x 33 signed product

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic CFG_PROCESS_NOISE     = 1'b0;
  localparam logic CFG_MEASUREMENT_NOISE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         slot;
    logic signed [31:0] meas_pos_x;
    logic signed [31:0] meas_pos_y;
    logic signed [31:0] meas_vel_x;
    logic signed [31:0] meas_vel_y;
    logic [31:0]        time_step;
  } item_t;

  typedef struct packed {
    logic [3:0]         out_slot;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
    logic [31:0]        var_x;
    logic [31:0]        var_y;
  } result_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        pos_var_x;
    logic [31:0]        pos_var_y;
    logic [31:0]        vel_var_x;
    logic [31:0]        vel_var_y;
    logic [31:0]        cross_x;
    logic [31:0]        cross_y;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] var_p;
    logic [32:0] den;
  } div_req_t;

  function automatic logic [31:0] sat_u32(input logic signed [PROD_W-1:0] v);
    logic [31:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({34'd0, 32'hFFFF_FFFF})) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed({34'd0, 32'h7FFF_FFFF})) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < $signed({{34{1'b1}}, 32'h8000_0000})) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/constant_velocity_track_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// constant_velocity_track_filter
// Table of 2-D constant-velocity track filters, fixed point, with a
// read-modify-write sequencer around a track memory with registered read.
// -----------------------------------------------------------------------------
// One item at a time. A start command goes from S_IDLE through S_WRAP and
// S_FIN back to S_IDLE. An update also loads the entry in S_LOAD, runs the
// predict states S_PM1 to S_PM4 and S_PPOS for each axis, and for each
// corrected component starts the shared restoring divider, which forms the
// four gains one quotient bit per cycle (a zero gain denominator gives a
// zero gain), then runs S_CM1 to S_CM3 around the single registered 33x33
// multiplier. A slot index at or above TRACK_SLOTS is wrapped first, one
// subtraction a cycle. The finished result sits in an output register, so the
// next item is taken while it waits; a result still stalled there when the
// next one is done holds the block until it is taken.
// -----------------------------------------------------------------------------
module constant_velocity_track_filter #(
  parameter int TRACK_SLOTS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  cvtf_pkg::item_t    item,
  output logic               result_valid,
  input  wire                result_stall,
  output cvtf_pkg::result_t  result,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_index,
  input  wire [31:0]         cfg_data
);

  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int KW     = FRAC_BITS + 1;
  localparam int PW     = cvtf_pkg::PROD_W;
  localparam logic [31:0]   ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic [KW-1:0] ONE_K  = KW'(64'd1 << FRAC_BITS);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_WRAP  = 14'b00000000000010,
    S_LOAD  = 14'b00000000000100,
    S_PM1   = 14'b00000000001000,
    S_PM2   = 14'b00000000010000,
    S_PM3   = 14'b00000000100000,
    S_PM4   = 14'b00000001000000,
    S_PPOS  = 14'b00000010000000,
    S_CDIVS = 14'b00000100000000,
    S_CDIV  = 14'b00001000000000,
    S_CM1   = 14'b00010000000000,
    S_CM2   = 14'b00100000000000,
    S_CM3   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state;

  logic [31:0]        q_noise;
  logic [31:0]        r_noise;
  logic               cmd_q;
  logic [3:0]         slot_q;
  logic [31:0]        dt_q;
  logic signed [31:0] zr [4];   // measurements, rotated with the state
  logic signed [31:0] xs [4];   // pos x, pos y, vel x, vel y
  logic [31:0]        ps [4];   // pos var x, pos var y, vel var x, vel var y
  logic [31:0]        cr [2];
  logic [31:0]        inc_q;
  logic [63:0]        t1_q;
  logic [KW-1:0]      k_q;
  logic               ax_q;
  logic [1:0]         comp_q;
  logic signed [PW-1:0] mul_q;

  logic signed [32:0]   op_a;
  logic signed [32:0]   op_b;
  logic signed [PW-1:0] shifted;
  logic signed [32:0]   diff;
  logic signed [PW-1:0] pv_sum;
  logic [31:0]          pv_new;
  logic [31:0]          vv_new;
  logic [31:0]          cr_new;
  logic signed [31:0]   pos_new;
  logic signed [31:0]   x_new;
  logic [31:0]          p_new;
  logic                 fin_go;

  cvtf_pkg::entry_t   rd_entry;
  cvtf_pkg::entry_t   wr_entry;
  cvtf_pkg::div_req_t div_req;
  logic               div_done;
  logic [KW-1:0]      div_k;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign fin_go     = (state == S_FIN) && (!result_valid || !result_stall);

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_PM1: begin
        op_a = $signed({1'b0, dt_q});
        op_b = $signed({1'b0, ps[2]});
      end
      S_PM2: begin
        op_a = $signed({1'b0, dt_q});
        op_b = $signed({1'b0, cr[0]});
      end
      S_PM3: begin
        op_a = $signed({1'b0, dt_q});
        op_b = $signed({1'b0, inc_q});
      end
      S_PM4: begin
        op_a = $signed({xs[2][31], xs[2]});
        op_b = $signed({1'b0, dt_q});
      end
      S_CM1: begin
        op_a = diff;
        op_b = $signed(33'(k_q));
      end
      S_CM2: begin
        op_a = $signed({1'b0, ps[0]});
        op_b = $signed(33'(ONE_K - k_q));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= PW'(op_a) * PW'(op_b);
  end

  // floor shift of the registered product
  assign shifted = mul_q >>> FRAC_BITS;
  assign diff    = 33'(zr[0]) - 33'(xs[0]);

  assign pv_sum  = $signed({34'd0, ps[0]}) + $signed({1'b0, t1_q, 1'b0}) + shifted;
  assign pv_new  = cvtf_pkg::sat_u32($signed({34'd0, cvtf_pkg::sat_u32(pv_sum)})
                                     + $signed({34'd0, q_noise}));
  assign vv_new  = cvtf_pkg::sat_u32($signed({34'd0, ps[2]}) + $signed({34'd0, q_noise}));
  assign cr_new  = cvtf_pkg::sat_u32($signed({34'd0, cr[0]}) + $signed({34'd0, inc_q}));
  assign pos_new = cvtf_pkg::sat_s32(PW'(xs[0]) + shifted);
  assign x_new   = cvtf_pkg::sat_s32(PW'(xs[0]) + shifted);
  assign p_new   = cvtf_pkg::sat_u32(shifted);

  assign div_req.start = (state == S_CDIVS);
  assign div_req.var_p = ps[0];
  assign div_req.den   = {1'b0, ps[0]} + {1'b0, r_noise};

  assign wr_entry.pos_x     = xs[0];
  assign wr_entry.pos_y     = xs[1];
  assign wr_entry.vel_x     = xs[2];
  assign wr_entry.vel_y     = xs[3];
  assign wr_entry.pos_var_x = ps[0];
  assign wr_entry.pos_var_y = ps[1];
  assign wr_entry.vel_var_x = ps[2];
  assign wr_entry.vel_var_y = ps[3];
  assign wr_entry.cross_x   = cr[0];
  assign wr_entry.cross_y   = cr[1];

  cvtf_track_mem #(
    .TRACK_SLOTS(TRACK_SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (fin_go),
    .wr_addr (SLOT_W'(slot_q)),
    .wr_data (wr_entry),
    .rd_addr (SLOT_W'(slot_q)),
    .rd_data (rd_entry)
  );

  cvtf_gain_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .k    (div_k)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= 32'd655;
      r_noise <= 32'd6554;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cvtf_pkg::CFG_PROCESS_NOISE:     q_noise <= cfg_data;
        cvtf_pkg::CFG_MEASUREMENT_NOISE: r_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      ax_q         <= 1'b0;
      comp_q       <= '0;
    end else begin
      if (fin_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (item_valid) state <= S_WRAP;
        S_WRAP: begin
          if ({5'd0, slot_q} < 9'(TRACK_SLOTS)) begin
            state <= (cmd_q == cvtf_pkg::CMD_UPDATE) ? S_LOAD : S_FIN;
          end
        end
        S_LOAD: begin
          ax_q  <= 1'b0;
          state <= S_PM1;
        end
        S_PM1:   state <= S_PM2;
        S_PM2:   state <= S_PM3;
        S_PM3:   state <= S_PM4;
        S_PM4:   state <= S_PPOS;
        S_PPOS: begin
          ax_q <= ~ax_q;
          if (ax_q) begin
            comp_q <= '0;
            state  <= S_CDIVS;
          end else begin
            state <= S_PM1;
          end
        end
        S_CDIVS: state <= S_CDIV;
        S_CDIV:  if (div_done) state <= S_CM1;
        S_CM1:   state <= S_CM2;
        S_CM2:   state <= S_CM3;
        S_CM3: begin
          comp_q <= comp_q + 2'd1;
          state  <= (comp_q == 2'd3) ? S_FIN : S_CDIVS;
        end
        S_FIN:   if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd_q  <= item.cmd;
          slot_q <= item.slot;
          dt_q   <= item.time_step;
          zr[0]  <= item.meas_pos_x;
          zr[1]  <= item.meas_pos_y;
          zr[2]  <= item.meas_vel_x;
          zr[3]  <= item.meas_vel_y;
          // start-track values; an update overwrites them from memory
          xs[0]  <= item.meas_pos_x;
          xs[1]  <= item.meas_pos_y;
          xs[2]  <= '0;
          xs[3]  <= '0;
          for (int i = 0; i < 4; i++) begin
            ps[i] <= ONE_FX;
          end
          cr[0]  <= '0;
          cr[1]  <= '0;
        end
      end
      S_WRAP: begin
        if ({5'd0, slot_q} >= 9'(TRACK_SLOTS)) begin
          slot_q <= slot_q - 4'(TRACK_SLOTS);
        end
      end
      S_LOAD: begin
        xs[0] <= rd_entry.pos_x;
        xs[1] <= rd_entry.pos_y;
        xs[2] <= rd_entry.vel_x;
        xs[3] <= rd_entry.vel_y;
        ps[0] <= rd_entry.pos_var_x;
        ps[1] <= rd_entry.pos_var_y;
        ps[2] <= rd_entry.vel_var_x;
        ps[3] <= rd_entry.vel_var_y;
        cr[0] <= rd_entry.cross_x;
        cr[1] <= rd_entry.cross_y;
      end
      S_PM2: inc_q <= cvtf_pkg::sat_u32(shifted);
      S_PM3: t1_q  <= shifted[63:0];
      S_PM4: begin
        ps[0] <= pv_new;
        ps[2] <= vv_new;
        cr[0] <= cr_new;
      end
      S_PPOS: begin
        // swap axes so the other one sits at the fixed working place
        xs[0] <= xs[1];
        xs[1] <= pos_new;
        xs[2] <= xs[3];
        xs[3] <= xs[2];
        ps[0] <= ps[1];
        ps[1] <= ps[0];
        ps[2] <= ps[3];
        ps[3] <= ps[2];
        cr[0] <= cr[1];
        cr[1] <= cr[0];
      end
      S_CDIV:  if (div_done) k_q <= div_k;
      S_CM2:   xs[0] <= x_new;
      S_CM3: begin
        // rotate all four components by one place
        xs[0] <= xs[1];
        xs[1] <= xs[2];
        xs[2] <= xs[3];
        xs[3] <= xs[0];
        ps[0] <= ps[1];
        ps[1] <= ps[2];
        ps[2] <= ps[3];
        ps[3] <= p_new;
        zr[0] <= zr[1];
        zr[1] <= zr[2];
        zr[2] <= zr[3];
        zr[3] <= zr[0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      result.out_slot <= slot_q;
      result.est_x    <= xs[0];
      result.est_y    <= xs[1];
      result.est_vx   <= xs[2];
      result.est_vy   <= xs[3];
      result.var_x    <= ps[0];
      result.var_y    <= ps[1];
    end
  end

endmodule
`default_nettype wire

[design/cvtf_track_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cvtf_track_mem
// Track entry table: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module cvtf_track_mem #(
  parameter int TRACK_SLOTS = 16,
  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1
) (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire [SLOT_W-1:0]       wr_addr,
  input  cvtf_pkg::entry_t       wr_data,
  input  wire [SLOT_W-1:0]       rd_addr,
  output cvtf_pkg::entry_t       rd_data
);

  cvtf_pkg::entry_t mem [TRACK_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/cvtf_gain_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cvtf_gain_div
// Restoring divider for the gain k = (P << F) / den, one quotient bit per
// cycle. P never exceeds den, so F+1 quotient bits suffice.
// -----------------------------------------------------------------------------
module cvtf_gain_div #(
  parameter int FRAC_BITS = 16,
  localparam int KW = FRAC_BITS + 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cvtf_pkg::div_req_t  req,
  output logic                done,
  output logic [KW-1:0]       k
);

  localparam int CNT_W = $clog2(KW);

  logic            busy;
  logic [33:0]     rem;
  logic [32:0]     den_q;
  logic [CNT_W-1:0] cnt;
  logic            ge;
  logic [33:0]     rem_sub;

  assign ge      = rem >= {1'b0, den_q};
  assign rem_sub = ge ? (rem - {1'b0, den_q}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          done <= 1'b1;      // zero denominator: gain is zero
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= {2'b00, req.var_p};
      den_q <= req.den;
      k     <= '0;
      cnt   <= CNT_W'(FRAC_BITS);
    end else if (busy) begin
      k   <= {k[KW-2:0], ge};
      rem <= {rem_sub[32:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

[design/cvtf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cvtf_checker
// Port-level checks of the track filter, bound to the top level.
// -----------------------------------------------------------------------------
module cvtf_checker (
  input wire                clk,
  input wire                rst,
  input wire                item_valid,
  input wire                item_stall,
  input wire                result_valid,
  input wire                result_stall,
  input cvtf_pkg::result_t  result,
  input wire                cfg_ready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after transfer");

  // a new result only comes out of a busy block
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result without an item in work");

  // register writes are never held off
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind constant_velocity_track_filter cvtf_checker u_cvtf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_ready    (cfg_ready)
);
`default_nettype wire
